### rtl/core/irr_pkg.sv
package irr_pkg;

    localparam int MaxWidth  = 128;
    localparam int MaxHeight = 128;
    localparam int PixelBits = 24;
    localparam int XW        = $clog2(MaxWidth);
    localparam int YW        = $clog2(MaxHeight);
    localparam int BankAw    = XW + YW;
    localparam int MemAw     = BankAw + 1;
    localparam int CoordW    = 12;
    localparam int SW        = CoordW + 2;

    typedef enum logic [1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_READ   = 2'd1,
        FUNC_ROTATE = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ANGLE = 2'd1,
        ST_OUTSIDE   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ANG_90  = 2'd0,
        ANG_180 = 2'd1,
        ANG_270 = 2'd2
    } ang_t;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_ROTATE = 2'd2,
        CMD_REPORT = 2'd3
    } cmd_kind_t;

    localparam logic [8:0] Angle90  = 9'd90;
    localparam logic [8:0] Angle180 = 9'd180;
    localparam logic [8:0] Angle270 = 9'd270;

    localparam logic CfgWidth  = 1'b0;
    localparam logic CfgHeight = 1'b1;

    typedef struct packed {
        cmd_kind_t              kind;
        status_t                status;
        ang_t                   ang;
        logic [XW-1:0]          px;
        logic [YW-1:0]          py;
        logic [PixelBits-1:0]   pixel;
        logic signed [SW-1:0]   xl;
        logic signed [SW-1:0]   xr;
        logic signed [SW-1:0]   yb;
        logic signed [SW-1:0]   ys;
        logic signed [SW-1:0]   w;
        logic signed [SW-1:0]   h;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_COPY,
        BK_COPY_WR,
        BK_ROT_RD,
        BK_ROT_WR,
        BK_READ_WAIT,
        BK_DONE
    } bk_state_t;

endpackage

### rtl/core/irr_front.sv
module irr_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           func,
    input  logic [11:0]          x_first,
    input  logic [11:0]          y_first,
    input  logic [11:0]          x_second,
    input  logic [11:0]          y_second,
    input  logic [8:0]           angle,
    input  logic [23:0]          pixel_in,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data,
    output logic                 q_valid,
    output irr_pkg::cmd_t        q_cmd,
    input  logic                 q_pop,
    input  logic                 back_idle
);
    import irr_pkg::*;

    logic [7:0]            width_reg;
    logic [7:0]            height_reg;
    logic signed [SW-1:0]  w_eff;
    logic signed [SW-1:0]  h_eff;
    cmd_t                  cmd;
    cmd_t                  fifo_reg [2];
    logic                  wp_reg;
    logic                  rp_reg;
    logic [1:0]            cnt_reg;
    logic signed [SW-1:0]  xs_c;
    logic signed [SW-1:0]  yf_c;
    logic                  push;
    logic                  pend_reg;

    always_comb
    begin
        w_eff = (width_reg == 8'd0) ? SW'(1) :
                (width_reg > 8'(MaxWidth - 1) && int'(width_reg) > MaxWidth) ? SW'(MaxWidth)
                : SW'(width_reg);
        h_eff = (height_reg == 8'd0) ? SW'(1) :
                (int'(height_reg) > MaxHeight) ? SW'(MaxHeight) : SW'(height_reg);
        xs_c  = SW'(x_second);
        yf_c  = SW'(y_first);
        cmd        = '0;
        cmd.w      = w_eff;
        cmd.h      = h_eff;
        cmd.px     = x_first[XW-1:0];
        cmd.py     = y_first[YW-1:0];
        cmd.pixel  = pixel_in[PixelBits-1:0];
        cmd.xl     = SW'(x_first);
        cmd.ys     = SW'(y_second);
        cmd.xr     = (xs_c < w_eff - SW'(1)) ? xs_c : w_eff - SW'(1);
        cmd.yb     = (yf_c < h_eff - SW'(1)) ? yf_c : h_eff - SW'(1);
        cmd.status = ST_OK;
        cmd.ang    = ANG_90;
        case (func_t'(func))
            FUNC_WRITE, FUNC_READ:
            begin
                if (SW'(x_first) >= w_eff || SW'(y_first) >= h_eff)
                begin
                    cmd.kind   = CMD_REPORT;
                    cmd.status = ST_OUTSIDE;
                end
                else
                begin
                    cmd.kind = (func_t'(func) == FUNC_WRITE) ? CMD_WRITE : CMD_READ;
                end
            end
            FUNC_ROTATE:
            begin
                if (angle == Angle90)
                begin
                    cmd.kind = CMD_ROTATE;
                    cmd.ang  = ANG_90;
                end
                else if (angle == Angle180)
                begin
                    cmd.kind = CMD_ROTATE;
                    cmd.ang  = ANG_180;
                end
                else if (angle == Angle270)
                begin
                    cmd.kind = CMD_ROTATE;
                    cmd.ang  = ANG_270;
                end
                else
                begin
                    cmd.kind   = CMD_REPORT;
                    cmd.status = ST_BAD_ANGLE;
                end
            end
            default: cmd.kind = CMD_REPORT;
        endcase
    end

    // one request in flight: busy from accept until the back end has finished
    assign busy   = pend_reg;
    assign push   = start && !pend_reg;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = fifo_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wp_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 8'd128;
            height_reg <= 8'd128;
            wp_reg     <= 1'b0;
            rp_reg     <= 1'b0;
            cnt_reg    <= 2'd0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CfgWidth)
            begin
                width_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CfgHeight)
            begin
                height_reg <= cfg_data;
            end
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
            if (push)
            begin
                pend_reg <= 1'b1;
            end
            else if (pend_reg && !q_valid && back_idle)
            begin
                pend_reg <= 1'b0;
            end
        end
    end

endmodule

### rtl/core/irr_back.sv
module irr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  irr_pkg::cmd_t        q_cmd,
    output logic                 q_pop,
    output logic                 idle,
    output logic                 done,
    output logic [23:0]          pixel_out,
    output logic [1:0]           status
);
    import irr_pkg::*;

    logic [PixelBits-1:0]  mem [2**MemAw];
    logic [PixelBits-1:0]  rdata_reg;
    bk_state_t             state_reg, state_next;
    cmd_t                  c_reg, c_next;
    logic                  bank_reg, bank_next;
    logic [BankAw-1:0]     idx_reg, idx_next;
    logic signed [SW-1:0]  x_reg, x_next;
    logic signed [SW-1:0]  y_reg, y_next;
    logic [PixelBits-1:0]  pout_reg, pout_next;
    logic [1:0]            st_reg, st_next;
    logic                  done_reg, done_next;
    logic                  we;
    logic [MemAw-1:0]      waddr;
    logic [MemAw-1:0]      raddr;
    logic [PixelBits-1:0]  wdata;
    logic                  re;
    logic signed [SW-1:0]  xc, yc, sx, sy, dx, dy;
    logic                  ok_pair;
    logic [BankAw-1:0]     dst_cell_reg, dst_cell_next;
    logic                  dok_reg, dok_next;

    assign idle      = (state_reg == BK_IDLE);
    assign done      = done_reg;
    assign pixel_out = pout_reg;
    assign status    = st_reg;

    always_comb
    begin
        xc = (c_reg.xl + c_reg.xr) >>> 1;
        yc = (c_reg.yb + c_reg.ys) >>> 1;
        if (c_reg.ang == ANG_180)
        begin
            sx = c_reg.xl + x_reg;
            sy = c_reg.yb - y_reg - SW'(1);
            dx = c_reg.xr - x_reg - SW'(1);
            dy = c_reg.ys + y_reg;
        end
        else
        begin
            dx = xc + (c_reg.yb - yc) - y_reg - SW'(1);
            dy = yc + (c_reg.xr - xc) - x_reg - SW'(1);
            if (c_reg.ang == ANG_90)
            begin
                sx = c_reg.xl + x_reg;
                sy = c_reg.yb - y_reg - SW'(1);
            end
            else
            begin
                sx = c_reg.xr - x_reg - SW'(1);
                sy = c_reg.ys + y_reg;
            end
        end
        ok_pair = !(dx < 0 || dx >= c_reg.w || dy < 0 || dy >= c_reg.h ||
                    sx < 0 || sx >= c_reg.w || sy < 0 || sy >= c_reg.h);
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        c_next        = c_reg;
        bank_next     = bank_reg;
        idx_next      = idx_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        pout_next     = pout_reg;
        st_next       = st_reg;
        done_next     = 1'b0;
        dst_cell_next = dst_cell_reg;
        dok_next      = dok_reg;
        q_pop         = 1'b0;
        we            = 1'b0;
        re            = 1'b0;
        waddr         = '0;
        raddr         = '0;
        wdata         = '0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    c_next    = q_cmd;
                    pout_next = '0;
                    st_next   = q_cmd.status;
                    case (q_cmd.kind)
                        CMD_WRITE:
                        begin
                            we         = 1'b1;
                            waddr      = {bank_reg, q_cmd.py, q_cmd.px};
                            wdata      = q_cmd.pixel;
                            state_next = BK_DONE;
                        end
                        CMD_READ:
                        begin
                            re         = 1'b1;
                            raddr      = {bank_reg, q_cmd.py, q_cmd.px};
                            state_next = BK_READ_WAIT;
                        end
                        CMD_ROTATE:
                        begin
                            idx_next   = '0;
                            state_next = BK_COPY;
                        end
                        default: state_next = BK_DONE;
                    endcase
                end
            end
            BK_READ_WAIT:
            begin
                pout_next  = rdata_reg;
                state_next = BK_DONE;
            end
            BK_COPY:
            begin
                re         = 1'b1;
                raddr      = {bank_reg, idx_reg};
                state_next = BK_COPY_WR;
            end
            BK_COPY_WR:
            begin
                we    = 1'b1;
                waddr = {~bank_reg, idx_reg};
                wdata = rdata_reg;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == '1)
                begin
                    x_next     = '0;
                    y_next     = '0;
                    state_next = BK_ROT_RD;
                end
                else
                begin
                    state_next = BK_COPY;
                end
            end
            BK_ROT_RD:
            begin
                if (y_reg >= c_reg.yb - c_reg.ys)
                begin
                    bank_next  = ~bank_reg;
                    state_next = BK_DONE;
                end
                else if (x_reg >= c_reg.xr - c_reg.xl)
                begin
                    x_next = '0;
                    y_next = y_reg + SW'(1);
                end
                else
                begin
                    re            = 1'b1;
                    raddr         = {bank_reg, sy[YW-1:0], sx[XW-1:0]};
                    dst_cell_next = {dy[YW-1:0], dx[XW-1:0]};
                    dok_next      = ok_pair;
                    x_next        = x_reg + SW'(1);
                    state_next    = BK_ROT_WR;
                end
            end
            BK_ROT_WR:
            begin
                we         = dok_reg;
                waddr      = {~bank_reg, dst_cell_reg};
                wdata      = rdata_reg;
                state_next = BK_ROT_RD;
            end
            BK_DONE:
            begin
                done_next  = 1'b1;
                state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        c_reg        <= c_next;
        idx_reg      <= idx_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        pout_reg     <= pout_next;
        st_reg       <= st_next;
        dst_cell_reg <= dst_cell_next;
        dok_reg      <= dok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            bank_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            done_reg  <= done_next;
        end
    end

endmodule

### rtl/core/image_region_rotator_unit.sv
// Two-bank 128x128 frame store of 24-bit pixels. One request at a time: busy is
// high from the accepting edge through the cycle in which its result strobes on
// done, and drops the cycle after; the result must be taken in its done cycle.
// Rotate copies all 16384 pixels of the active bank to the other bank, each read then
// written, then reads and writes each region pixel to its rotated place and swaps banks.
// Bad angle or out-of-image access answers with its status and nothing written.
module image_region_rotator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [11:0] x_first,
    input  logic [11:0] y_first,
    input  logic [11:0] x_second,
    input  logic [11:0] y_second,
    input  logic [8:0]  angle,
    input  logic [23:0] pixel_in,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    output logic        done,
    output logic [23:0] pixel_out,
    output logic [1:0]  status
);
    import irr_pkg::*;

    logic  q_valid;
    logic  q_pop;
    logic  back_idle;
    cmd_t  q_cmd;

    irr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .x_first   (x_first),
        .y_first   (y_first),
        .x_second  (x_second),
        .y_second  (y_second),
        .angle     (angle),
        .pixel_in  (pixel_in),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .back_idle (back_idle)
    );

    irr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .idle      (back_idle),
        .done      (done),
        .pixel_out (pixel_out),
        .status    (status)
    );

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import irr_pkg::*;

    localparam int BankSz = MaxWidth * MaxHeight;

    typedef struct {
        func_t       fn;
        logic [11:0] xf;
        logic [11:0] yf;
        logic [11:0] xs;
        logic [11:0] ys;
        logic [8:0]  ang;
        logic [23:0] pix;
    } request_t;

    typedef struct {
        logic [23:0] pix;
        status_t     st;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    logic [11:0] x_first;
    logic [11:0] y_first;
    logic [11:0] x_second;
    logic [11:0] y_second;
    logic [8:0]  angle;
    logic [23:0] pixel_in;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic        done;
    logic [23:0] pixel_out;
    logic [1:0]  status;

    image_region_rotator_unit u_dut (.*);

    request_t    pending_q[$];
    answer_t     answer_q[$];
    int          errors;
    bit          took;
    bit          gaps_on;
    int          gap_left;

    // frame store copy, with a written flag per pixel
    logic [23:0] frame[2][BankSz];
    bit          written[2][BankSz];
    bit          bank;
    logic [7:0]  reg_w;
    logic [7:0]  reg_h;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int eff_dim(logic [7:0] r, int mx);
        if (r == 0)
            return 1;
        if (r > mx)
            return mx;
        return r;
    endfunction

    function automatic answer_t rotate_image(request_t rq);
        answer_t a;
        int w, h, xl, xr, yb, ys, xc, yc, sx, sy, dx, dy;
        bit dst;
        w = eff_dim(reg_w, MaxWidth);
        h = eff_dim(reg_h, MaxHeight);
        xl = rq.xf;
        ys = rq.ys;
        xr = (rq.xs < w - 1) ? int'(rq.xs) : w - 1;
        yb = (rq.yf < h - 1) ? int'(rq.yf) : h - 1;
        a.pix = '0;
        a.st = ST_OK;
        if (rq.ang != Angle90 && rq.ang != Angle180 && rq.ang != Angle270)
        begin
            a.st = ST_BAD_ANGLE;
            return a;
        end
        dst = ~bank;
        for (int i = 0; i < BankSz; i++)
        begin
            frame[dst][i] = frame[bank][i];
            written[dst][i] = written[bank][i];
        end
        xc = (xl + xr) / 2;
        yc = (yb + ys) / 2;
        for (int y = 0; y < yb - ys; y++)
            for (int x = 0; x < xr - xl; x++)
            begin
                if (rq.ang == Angle180)
                begin
                    sx = xl + x; sy = yb - y - 1;
                    dx = xr - x - 1; dy = ys + y;
                end
                else
                begin
                    dx = xc + (yb - yc) - y - 1;
                    dy = yc + (xr - xc) - x - 1;
                    if (rq.ang == Angle90)
                    begin
                        sx = xl + x; sy = yb - y - 1;
                    end
                    else
                    begin
                        sx = xr - x - 1; sy = ys + y;
                    end
                end
                if (dx < 0 || dx >= w || dy < 0 || dy >= h)
                    continue;
                if (sx < 0 || sx >= w || sy < 0 || sy >= h)
                    continue;
                frame[dst][dy * MaxWidth + dx] = frame[bank][sy * MaxWidth + sx];
                written[dst][dy * MaxWidth + dx] = written[bank][sy * MaxWidth + sx];
            end
        bank = dst;
        return a;
    endfunction

    function automatic answer_t apply_request(request_t rq);
        answer_t a;
        int idx;
        a.pix = '0;
        a.st = ST_OK;
        idx = rq.yf * MaxWidth + rq.xf;
        if (rq.fn == FUNC_WRITE || rq.fn == FUNC_READ)
        begin
            if (rq.xf >= eff_dim(reg_w, MaxWidth) || rq.yf >= eff_dim(reg_h, MaxHeight))
                a.st = ST_OUTSIDE;
            else if (rq.fn == FUNC_WRITE)
            begin
                frame[bank][idx] = rq.pix;
                written[bank][idx] = 1'b1;
            end
            else
                a.pix = frame[bank][idx];
        end
        else if (rq.fn == FUNC_ROTATE)
            a = rotate_image(rq);
        return a;
    endfunction

    function automatic bit in_image(int x, int y);
        return x < eff_dim(reg_w, MaxWidth) && y < eff_dim(reg_h, MaxHeight);
    endfunction

    // never read a pixel that was not written: retry, else turn into a write
    task automatic queue_request(func_t fn, int xf, int yf, int xs, int ys, int ang, int pix);
        request_t rq;
        int wn, hn;
        wn = (eff_dim(reg_w, MaxWidth) < 16) ? eff_dim(reg_w, MaxWidth) : 16;
        hn = (eff_dim(reg_h, MaxHeight) < 16) ? eff_dim(reg_h, MaxHeight) : 16;
        for (int k = 0; k < 20 && fn == FUNC_READ && in_image(xf, yf)
             && !written[bank][yf * MaxWidth + xf]; k++)
        begin
            xf = $urandom_range(0, wn - 1);
            yf = $urandom_range(0, hn - 1);
        end
        if (fn == FUNC_READ && in_image(xf, yf) && !written[bank][yf * MaxWidth + xf])
            fn = FUNC_WRITE;
        rq.fn = fn;
        rq.xf = xf;
        rq.yf = yf;
        rq.xs = xs;
        rq.ys = ys;
        rq.ang = ang;
        rq.pix = pix;
        answer_q.push_back(apply_request(rq));
        pending_q.push_back(rq);
    endtask

    task automatic random_request();
        int r, wn, hn, ang;
        wn = (eff_dim(reg_w, MaxWidth) < 16) ? eff_dim(reg_w, MaxWidth) : 16;
        hn = (eff_dim(reg_h, MaxHeight) < 16) ? eff_dim(reg_h, MaxHeight) : 16;
        r = $urandom_range(0, 99);
        if (r < 40)
            queue_request(FUNC_WRITE, $urandom_range(0, wn - 1), $urandom_range(0, hn - 1),
                          $urandom, $urandom, $urandom, $urandom);
        else if (r < 75)
            queue_request(FUNC_READ, $urandom_range(0, wn - 1), $urandom_range(0, hn - 1),
                          $urandom, $urandom, $urandom, $urandom);
        else if (r < 80)
            queue_request(r[0] ? FUNC_READ : FUNC_WRITE, $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom, $urandom, $urandom, $urandom);
        else if (r < 83)
            queue_request(FUNC_NONE, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom);
        else if (r < 86)
            queue_request(FUNC_ROTATE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 511), $urandom);
        else
        begin
            case ($urandom_range(0, 2))
                0: ang = Angle90;
                1: ang = Angle180;
                default: ang = Angle270;
            endcase
            if (r < 96)
                queue_request(FUNC_ROTATE, $urandom_range(0, wn - 1), $urandom_range(0, hn + 1),
                              $urandom_range(0, wn + 1), $urandom_range(0, hn - 1), ang,
                              $urandom);
            else
                queue_request(FUNC_ROTATE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                              $urandom_range(0, 4095), $urandom_range(0, 4095), ang,
                              $urandom);
        end
    endtask

    task automatic wait_idle();
        wait (pending_q.size() == 0 && answer_q.size() == 0 && !start);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CfgWidth)
            reg_w = val;
        else
            reg_h = val;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(negedge clk or negedge rst_n)
    begin
        request_t rq;
        if (!rst_n)
            start <= 1'b0;
        else if (!start || took)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                rq = pending_q.pop_front();
                func <= rq.fn;
                x_first <= rq.xf;
                y_first <= rq.yf;
                x_second <= rq.xs;
                y_second <= rq.ys;
                angle <= rq.ang;
                pixel_in <= rq.pix;
                start <= 1'b1;
                gap_left = gaps_on ? $urandom_range(0, 11) : 0;
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        answer_t a;
        took = rst_n && start && !busy;
        if (rst_n && done)
        begin
            if (answer_q.size() == 0)
                report_mismatch("unexpected result", status, 0);
            else
            begin
                a = answer_q.pop_front();
                if (pixel_out !== a.pix)
                    report_mismatch("pixel_out", pixel_out, a.pix);
                if (status !== a.st)
                    report_mismatch("status", status, a.st);
            end
        end
    end

    initial
    begin
        #200_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        logic [7:0] cw[5];
        logic [7:0] ch[5];
        cw = '{8'd0, 8'd255, 8'd1, 8'd7, 8'd128};
        ch = '{8'd255, 8'd0, 8'd1, 8'd13, 8'd128};
        errors = 0;
        gaps_on = 1'b1;
        gap_left = 0;
        took = 1'b0;
        bank = 1'b0;
        reg_w = 8'd128;
        reg_h = 8'd128;
        rst_n = 1'b0;
        start = 1'b0;
        func = '0;
        x_first = '0;
        y_first = '0;
        x_second = '0;
        y_second = '0;
        angle = '0;
        pixel_in = '0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int y = 0; y < 4; y++)
            queue_request(FUNC_WRITE, y, y, 0, 0, 0, {8'(y), 16'h5a00 + 16'(y)});
        queue_request(FUNC_WRITE, 1, 0, 0, 0, 0, 24'hffffff);
        queue_request(FUNC_WRITE, 0, 1, 0, 0, 0, 24'h000000);
        queue_request(FUNC_WRITE, 127, 127, 0, 0, 0, 24'h123456);
        queue_request(FUNC_READ, 127, 127, 0, 0, 0, 0);
        queue_request(FUNC_READ, 1, 0, 0, 0, 0, 0);
        queue_request(FUNC_READ, 128, 0, 0, 0, 0, 0);
        queue_request(FUNC_READ, 0, 4095, 0, 0, 0, 0);
        queue_request(FUNC_WRITE, 4095, 4095, 0, 0, 0, 24'hffffff);
        queue_request(FUNC_NONE, 4095, 4095, 4095, 4095, 511, 24'hffffff);
        queue_request(FUNC_ROTATE, 0, 4, 4, 0, 0, 0);
        queue_request(FUNC_ROTATE, 0, 4, 4, 0, 511, 0);
        queue_request(FUNC_ROTATE, 0, 4, 4, 0, Angle180, 0);
        queue_request(FUNC_READ, 3, 0, 0, 0, 0, 0);
        queue_request(FUNC_ROTATE, 0, 4, 4, 0, Angle90, 0);
        queue_request(FUNC_READ, 2, 1, 0, 0, 0, 0);
        queue_request(FUNC_ROTATE, 1, 5, 4, 0, Angle270, 0);
        queue_request(FUNC_READ, 1, 1, 0, 0, 0, 0);
        queue_request(FUNC_ROTATE, 5, 4, 2, 0, Angle90, 0);
        queue_request(FUNC_ROTATE, 120, 4095, 4095, 122, Angle180, 0);
        queue_request(FUNC_READ, 127, 122, 0, 0, 0, 0);

        for (int p = 0; p < 5; p++)
        begin
            wait_idle();
            write_reg(CfgWidth, cw[p]);
            write_reg(CfgHeight, ch[p]);
            gaps_on = (p != 2);
            for (int i = 0; i < 20; i++)
                random_request();
        end

        wait (pending_q.size() == 0 && answer_q.size() == 0 && !start);
        repeat (40) @(posedge clk);
        if (errors == 0 && answer_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/core/irr_pkg.sv
rtl/core/irr_front.sv
rtl/core/irr_back.sv
rtl/core/image_region_rotator_unit.sv
tb/tb.sv
